// ===== rtl/core/rgbpwm_pkg.sv =====
// -----------------------------------------------------------------------------
// rgbpwm_pkg
// Shared constants and helper functions for the rgb hex command to pwm block.
// -----------------------------------------------------------------------------
package rgbpwm_pkg;

    localparam logic [7:0]  CH_CR    = 8'd13;
    localparam logic [7:0]  CH_NONE  = 8'd255;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_HASH  = 8'h23;
    localparam logic [7:0]  CH_R     = 8'h72;
    localparam logic [7:0]  CH_G     = 8'h67;
    localparam logic [7:0]  CH_B     = 8'h62;
    localparam logic [7:0]  CH_0     = 8'h30;
    localparam logic [7:0]  CH_9     = 8'h39;
    localparam logic [7:0]  CH_LA    = 8'h61;
    localparam logic [7:0]  CH_LF    = 8'h66;
    localparam logic [7:0]  CH_UA    = 8'h41;
    localparam logic [7:0]  CH_UF    = 8'h46;

    localparam logic [2:0]  DIGITS_NEEDED = 3'd6;
    localparam logic [15:0] PERIOD_RESET  = 16'd1000;

    // period split as p = 255 * quot + rem
    typedef struct packed {
        logic [8:0] quot;
        logic [7:0] rem;
    } period_split_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (ch >= CH_0 && ch <= CH_9)
            begin
                d = ch - CH_0;
                hex_decode = {1'b1, d[3:0]};
            end
            else if (ch >= CH_LA && ch <= CH_LF)
            begin
                d = ch - CH_LA + 8'd10;
                hex_decode = {1'b1, d[3:0]};
            end
            else if (ch >= CH_UA && ch <= CH_UF)
            begin
                d = ch - CH_UA + 8'd10;
                hex_decode = {1'b1, d[3:0]};
            end
            else
            begin
                hex_decode = {1'b0, d[3:0]};
            end
        end
    endfunction

    // divide by 255 with reciprocal estimate and one correction step
    function automatic period_split_t split_period(input logic [15:0] p);
        logic [17:0] sum;
        logic [8:0]  q0;
        logic [16:0] r0;
        period_split_t s;
        begin
            sum = {2'b00, p} + 18'd1 + {10'd0, p[15:8]};
            q0  = sum[16:8];
            r0  = {1'b0, p} - (({8'd0, q0} << 8) - {8'd0, q0});
            if (r0 >= 17'd255)
            begin
                s.quot = q0 + 9'd1;
                s.rem  = 8'(r0 - 17'd255);
            end
            else
            begin
                s.quot = q0;
                s.rem  = r0[7:0];
            end
            split_period = s;
        end
    endfunction

    // p - floor(c * p / 255) using p = 255 * quot + rem
    function automatic logic [15:0] to_compare(input logic [7:0] c,
                                               input period_split_t s,
                                               input logic [15:0] p);
        logic [16:0] prod_q;
        logic [15:0] prod_r;
        logic [16:0] sum;
        logic [7:0]  frac;
        logic [16:0] scaled;
        begin
            prod_q = {9'd0, c} * {8'd0, s.quot};
            prod_r = {8'd0, c} * {8'd0, s.rem};
            // exact floor(y / 255) for y below 65280
            sum    = {1'b0, prod_r} + 17'd1 + {9'd0, prod_r[15:8]};
            frac   = sum[15:8];
            scaled = prod_q + {9'd0, frac};
            to_compare = 16'({1'b0, p} - scaled);
        end
    endfunction

endpackage

// ===== rtl/core/rgbpwm_byte_if.sv =====
// -----------------------------------------------------------------------------
// rgbpwm_byte_if
// Received byte channel with valid/ready handshake.
// -----------------------------------------------------------------------------
interface rgbpwm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/rgbpwm_result_if.sv =====
// -----------------------------------------------------------------------------
// rgbpwm_result_if
// Line result channel: status flag and the three held compare values.
// -----------------------------------------------------------------------------
interface rgbpwm_result_if;
    logic        valid;
    logic        ready;
    logic        line_ok;
    logic [15:0] red_compare;
    logic [15:0] green_compare;
    logic [15:0] blue_compare;

    modport source (output valid, output line_ok, output red_compare,
                    output green_compare, output blue_compare, input ready);
    modport sink   (input valid, input line_ok, input red_compare,
                    input green_compare, input blue_compare, output ready);
endinterface

// ===== rtl/core/rgb_hex_command_to_pwm_top.sv =====
// -----------------------------------------------------------------------------
// rgb_hex_command_to_pwm_top
// Parses "rgb #RRGGBB" / "rbg #RRGGBB" lines and holds pwm compare values.
// -----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  rx      | in  | valid/ready        | rx_byte[7:0]
//  res     | out | valid/ready        | line_ok, red/green/blue_compare[15:0]
//  cfg     | in  | cfg_we, no ready   | cfg_wdata[15:0] (pwm_period)
//
//  one byte per cycle while rx.ready is high; parsing and compare math finish
//  in the cycle the byte is taken, a carriage return loads the result register
//  at the edge that takes it, so the result is offered from the next cycle on
//  rx.ready drops only while a result waits and res.ready is low
//  reset: parser at start of line, period 1000, compares 1000, no result
// -----------------------------------------------------------------------------
module rgb_hex_command_to_pwm_top
(
    input  logic                   clk,
    input  logic                   rst_n,
    rgbpwm_byte_if.sink            rx,
    rgbpwm_result_if.source        res,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata
);

    typedef enum logic [3:0] {
        PH_START,
        PH_AFTER_R,
        PH_AFTER_RG,
        PH_AFTER_RB,
        PH_WORD_DONE,
        PH_WANT_HASH,
        PH_DIGITS,
        PH_AFTER_DIGITS,
        PH_TAIL
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [2:0]                 count_reg, count_next;
    logic                       bad_reg, bad_next;
    logic [23:0]                accum_reg, accum_next;
    logic [15:0]                period_reg;
    rgbpwm_pkg::period_split_t  split_reg;
    logic [15:0]                red_reg, green_reg, blue_reg;
    logic [15:0]                red_next, green_next, blue_next;
    logic                       ok_reg, ok_next;
    logic                       valid_reg, valid_next;

    logic                       accept;
    logic                       is_cr;
    logic                       good;
    logic [4:0]                 hex;
    logic [2:0]                 count_inc;

    assign rx.ready  = !valid_reg || res.ready;
    assign accept    = rx.valid && rx.ready;
    assign is_cr     = (rx.rx_byte == rgbpwm_pkg::CH_CR);
    assign hex       = rgbpwm_pkg::hex_decode(rx.rx_byte);
    assign count_inc = count_reg + 3'd1;
    assign good      = !bad_reg && (phase_reg == PH_AFTER_DIGITS || phase_reg == PH_TAIL);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        accum_next = accum_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        ok_next    = ok_reg;
        valid_next = valid_reg && !res.ready;

        if (accept && rx.rx_byte != rgbpwm_pkg::CH_NONE)
        begin
            if (is_cr)
            begin
                valid_next = 1'b1;
                ok_next    = good;
                if (good)
                begin
                    red_next   = rgbpwm_pkg::to_compare(accum_reg[23:16], split_reg,
                                                        period_reg);
                    green_next = rgbpwm_pkg::to_compare(accum_reg[15:8], split_reg,
                                                        period_reg);
                    blue_next  = rgbpwm_pkg::to_compare(accum_reg[7:0], split_reg,
                                                        period_reg);
                end
                phase_next = PH_START;
                count_next = 3'd0;
                bad_next   = 1'b0;
                accum_next = 24'd0;
            end
            else if (!bad_reg)
            begin
                bad_next = 1'b1;
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_R)
                        begin
                            phase_next = PH_AFTER_R;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_AFTER_R:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_G)
                        begin
                            phase_next = PH_AFTER_RG;
                            bad_next   = 1'b0;
                        end
                        else if (rx.rx_byte == rgbpwm_pkg::CH_B)
                        begin
                            phase_next = PH_AFTER_RB;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_AFTER_RG:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_B)
                        begin
                            phase_next = PH_WORD_DONE;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_AFTER_RB:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_G)
                        begin
                            phase_next = PH_WORD_DONE;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_WORD_DONE:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_SPACE)
                        begin
                            phase_next = PH_WANT_HASH;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_WANT_HASH:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_HASH)
                        begin
                            phase_next = PH_DIGITS;
                            count_next = 3'd0;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (hex[4])
                        begin
                            accum_next = {accum_reg[19:0], hex[3:0]};
                            count_next = count_inc;
                            bad_next   = 1'b0;
                            if (count_inc >= rgbpwm_pkg::DIGITS_NEEDED)
                            begin
                                phase_next = PH_AFTER_DIGITS;
                            end
                        end
                    end
                    PH_AFTER_DIGITS:
                    begin
                        if (rx.rx_byte == rgbpwm_pkg::CH_SPACE)
                        begin
                            phase_next = PH_TAIL;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_TAIL:
                    begin
                        bad_next = 1'b0;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            count_reg  <= 3'd0;
            bad_reg    <= 1'b0;
            accum_reg  <= 24'd0;
            period_reg <= rgbpwm_pkg::PERIOD_RESET;
            split_reg  <= rgbpwm_pkg::split_period(rgbpwm_pkg::PERIOD_RESET);
            red_reg    <= rgbpwm_pkg::PERIOD_RESET;
            green_reg  <= rgbpwm_pkg::PERIOD_RESET;
            blue_reg   <= rgbpwm_pkg::PERIOD_RESET;
            ok_reg     <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
            accum_reg <= accum_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            ok_reg    <= ok_next;
            valid_reg <= valid_next;
            // quotient and remainder by 255 kept ready for the compare math
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
                split_reg  <= rgbpwm_pkg::split_period(cfg_wdata);
            end
        end
    end

    // held compares change only when a new transaction replaces the result
    assign res.valid         = valid_reg;
    assign res.line_ok       = ok_reg;
    assign res.red_compare   = red_reg;
    assign res.green_compare = green_reg;
    assign res.blue_compare  = blue_reg;

endmodule
